// ===== rtl/aaie_pkg.sv =====
// shared types and constants for the accumulator alu instruction core
// no dependencies
`default_nettype none

package aaie_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ACC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAGS = 3'd5;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_LXI_B  = 8'h01;
  localparam logic [7:0] OP_ALU_LO = 8'h80;
  localparam logic [7:0] OP_ALU_HI = 8'hA7;

  localparam int FLAG_Z_BIT  = 0;
  localparam int FLAG_S_BIT  = 1;
  localparam int FLAG_P_BIT  = 2;
  localparam int FLAG_CY_BIT = 3;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] mem_at_hl;
  } in_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  acc_out;
    logic [15:0] bc_out;
    logic [15:0] hl_addr;
    logic        zero_flag;
    logic        sign_flag;
    logic        parity_flag;
    logic        carry_flag;
    logic        halted;
  } out_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LXI,
    KIND_ALU,
    KIND_ILLEGAL
  } kind_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_ADC,
    ALU_SUB,
    ALU_SBB,
    ALU_ANA
  } alu_op_t;

  typedef enum logic [2:0] {
    SRC_B,
    SRC_C,
    SRC_D,
    SRC_E,
    SRC_H,
    SRC_L,
    SRC_M,
    SRC_A
  } src_t;

  typedef struct packed {
    kind_t      kind;
    alu_op_t    alu_op;
    src_t       src;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] mem;
  } dec_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/aaie_front.sv =====
// front end: classifies an incoming instruction word into a decoded word
// depends on aaie_pkg
`default_nettype none

module aaie_front (
  input  wire aaie_pkg::in_t  in_word,
  output aaie_pkg::dec_t      dec_word
);

  always_comb begin
    dec_word.kind     = aaie_pkg::KIND_ILLEGAL;
    dec_word.alu_op   = aaie_pkg::ALU_ANA;
    dec_word.src      = aaie_pkg::src_t'(in_word.opcode[2:0]);
    dec_word.imm_low  = in_word.imm_low;
    dec_word.imm_high = in_word.imm_high;
    dec_word.mem      = in_word.mem_at_hl;
    if (in_word.opcode == aaie_pkg::OP_NOP) begin
      dec_word.kind = aaie_pkg::KIND_NOP;
    end else if (in_word.opcode == aaie_pkg::OP_LXI_B) begin
      dec_word.kind = aaie_pkg::KIND_LXI;
    end else if (in_word.opcode inside {[aaie_pkg::OP_ALU_LO:aaie_pkg::OP_ALU_HI]}) begin
      dec_word.kind = aaie_pkg::KIND_ALU;
      case (in_word.opcode[5:3])
        3'd0: dec_word.alu_op = aaie_pkg::ALU_ADD;
        3'd1: dec_word.alu_op = aaie_pkg::ALU_ADC;
        3'd2: dec_word.alu_op = aaie_pkg::ALU_SUB;
        3'd3: dec_word.alu_op = aaie_pkg::ALU_SBB;
        default: dec_word.alu_op = aaie_pkg::ALU_ANA;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aaie_queue.sv =====
// small fifo of decoded words between front and back end
// depends on aaie_pkg
`default_nettype none

module aaie_queue #(
  parameter int DEPTH = aaie_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire aaie_pkg::dec_t push_word,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output aaie_pkg::dec_t      pop_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  aaie_pkg::dec_t           slot_r [DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_word  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aaie_back.sv =====
// back end: register file, alu, flags, halt, start registers and result register
// depends on aaie_pkg
`default_nettype none

module aaie_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aaie_pkg::cfg_wr_t cfg_wr,
  input  wire logic              q_not_empty,
  input  wire aaie_pkg::dec_t    q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output aaie_pkg::out_t         out_data
);

  logic [15:0] cfg_pc_r, cfg_bc_r, cfg_de_r, cfg_hl_r;
  logic [7:0]  cfg_acc_r;
  logic [3:0]  cfg_flags_r;
  logic [15:0] cfg_pc_nxt, cfg_bc_nxt, cfg_de_nxt, cfg_hl_nxt;
  logic [7:0]  cfg_acc_nxt;
  logic [3:0]  cfg_flags_nxt;
  logic        cfg_hit;

  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  b_r, b_nxt, c_r, c_nxt, d_r, e_r, h_r, l_r;
  logic [3:0]  flags_r, flags_nxt;
  logic        halt_r, halt_nxt;

  logic        out_valid_r;
  aaie_pkg::out_t out_data_r, out_data_nxt;

  logic [7:0]  src_val;
  logic [8:0]  alu_res;
  logic        cy_in;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cy_in     = flags_r[aaie_pkg::FLAG_CY_BIT];

  always_comb begin
    cfg_pc_nxt    = cfg_pc_r;
    cfg_acc_nxt   = cfg_acc_r;
    cfg_bc_nxt    = cfg_bc_r;
    cfg_de_nxt    = cfg_de_r;
    cfg_hl_nxt    = cfg_hl_r;
    cfg_flags_nxt = cfg_flags_r;
    cfg_hit       = 1'b0;
    if (cfg_wr.wr) begin
      case (cfg_wr.idx)
        aaie_pkg::CFG_START_PC: begin
          cfg_pc_nxt = cfg_wr.data;
          cfg_hit    = 1'b1;
        end
        aaie_pkg::CFG_START_ACC: begin
          cfg_acc_nxt = cfg_wr.data[7:0];
          cfg_hit     = 1'b1;
        end
        aaie_pkg::CFG_START_BC: begin
          cfg_bc_nxt = cfg_wr.data;
          cfg_hit    = 1'b1;
        end
        aaie_pkg::CFG_START_DE: begin
          cfg_de_nxt = cfg_wr.data;
          cfg_hit    = 1'b1;
        end
        aaie_pkg::CFG_START_HL: begin
          cfg_hl_nxt = cfg_wr.data;
          cfg_hit    = 1'b1;
        end
        aaie_pkg::CFG_START_FLAGS: begin
          cfg_flags_nxt = cfg_wr.data[3:0];
          cfg_hit       = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (q_word.src)
      aaie_pkg::SRC_B: src_val = b_r;
      aaie_pkg::SRC_C: src_val = c_r;
      aaie_pkg::SRC_D: src_val = d_r;
      aaie_pkg::SRC_E: src_val = e_r;
      aaie_pkg::SRC_H: src_val = h_r;
      aaie_pkg::SRC_L: src_val = l_r;
      aaie_pkg::SRC_M: src_val = q_word.mem;
      default:         src_val = acc_r;
    endcase
    case (q_word.alu_op)
      aaie_pkg::ALU_ADD: alu_res = {1'b0, acc_r} + {1'b0, src_val};
      aaie_pkg::ALU_ADC: alu_res = {1'b0, acc_r} + {1'b0, src_val} + {8'd0, cy_in};
      aaie_pkg::ALU_SUB: alu_res = {1'b0, acc_r} - {1'b0, src_val};
      aaie_pkg::ALU_SBB: alu_res = {1'b0, acc_r} - {1'b0, src_val} - {8'd0, cy_in};
      default:           alu_res = {1'b0, acc_r & src_val};
    endcase
  end

  always_comb begin
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    flags_nxt = flags_r;
    halt_nxt  = halt_r;
    if (!halt_r) begin
      case (q_word.kind)
        aaie_pkg::KIND_NOP: pc_nxt = pc_r + 16'd1;
        aaie_pkg::KIND_LXI: begin
          b_nxt  = q_word.imm_high;
          c_nxt  = q_word.imm_low;
          pc_nxt = pc_r + 16'd3;
        end
        aaie_pkg::KIND_ALU: begin
          acc_nxt                           = alu_res[7:0];
          flags_nxt[aaie_pkg::FLAG_Z_BIT]  = (alu_res[7:0] == 8'd0);
          flags_nxt[aaie_pkg::FLAG_S_BIT]  = alu_res[7];
          flags_nxt[aaie_pkg::FLAG_P_BIT]  = ~^alu_res[7:0];
          flags_nxt[aaie_pkg::FLAG_CY_BIT] =
            (q_word.alu_op == aaie_pkg::ALU_ANA) ? 1'b0 : alu_res[8];
          pc_nxt                            = pc_r + 16'd1;
        end
        default: halt_nxt = 1'b1;
      endcase
    end
    out_data_nxt.next_pc     = pc_nxt;
    out_data_nxt.acc_out     = acc_nxt;
    out_data_nxt.bc_out      = {b_nxt, c_nxt};
    out_data_nxt.hl_addr     = {h_r, l_r};
    out_data_nxt.zero_flag   = flags_nxt[aaie_pkg::FLAG_Z_BIT];
    out_data_nxt.sign_flag   = flags_nxt[aaie_pkg::FLAG_S_BIT];
    out_data_nxt.parity_flag = flags_nxt[aaie_pkg::FLAG_P_BIT];
    out_data_nxt.carry_flag  = flags_nxt[aaie_pkg::FLAG_CY_BIT];
    out_data_nxt.halted      = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pc_r    <= '0;
      cfg_acc_r   <= '0;
      cfg_bc_r    <= '0;
      cfg_de_r    <= '0;
      cfg_hl_r    <= '0;
      cfg_flags_r <= '0;
      pc_r        <= '0;
      acc_r       <= '0;
      b_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
      e_r         <= '0;
      h_r         <= '0;
      l_r         <= '0;
      flags_r     <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_pc_r    <= cfg_pc_nxt;
      cfg_acc_r   <= cfg_acc_nxt;
      cfg_bc_r    <= cfg_bc_nxt;
      cfg_de_r    <= cfg_de_nxt;
      cfg_hl_r    <= cfg_hl_nxt;
      cfg_flags_r <= cfg_flags_nxt;
      if (cfg_hit) begin
        pc_r    <= cfg_pc_nxt;
        acc_r   <= cfg_acc_nxt;
        b_r     <= cfg_bc_nxt[15:8];
        c_r     <= cfg_bc_nxt[7:0];
        d_r     <= cfg_de_nxt[15:8];
        e_r     <= cfg_de_nxt[7:0];
        h_r     <= cfg_hl_nxt[15:8];
        l_r     <= cfg_hl_nxt[7:0];
        flags_r <= cfg_flags_nxt;
      end else if (q_pop) begin
        pc_r    <= pc_nxt;
        acc_r   <= acc_nxt;
        b_r     <= b_nxt;
        c_r     <= c_nxt;
        flags_r <= flags_nxt;
        halt_r  <= halt_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/accumulator_alu_instruction_exec_core.sv =====
// One instruction word is taken per cycle while the queue has room, and one
// result word comes back for each, in order, with the register state after
// that instruction. A word passes the decoder into a short queue, then the
// execute stage updates the accumulator, registers and flags and loads the
// result register. One word per cycle is sustained while results are taken,
// bounded by the single execute stage that reads and writes the register
// file each cycle. The queue absorbs stalls on the result side so the input
// keeps flowing until it fills. Configuration writes are taken in any cycle
// and reload the working registers from the start values; the halt flag survives them.
// depends on aaie_pkg, aaie_front, aaie_queue, aaie_back
`default_nettype none

module accumulator_alu_instruction_exec_core #(
  parameter int QUEUE_DEPTH = aaie_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire aaie_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output aaie_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [aaie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aaie_pkg::CFG_DATA_W-1:0] cfg_data
);

  aaie_pkg::dec_t    dec_word;
  aaie_pkg::dec_t    q_word;
  aaie_pkg::cfg_wr_t cfg_wr;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;

  assign in_ready    = !q_full;
  assign cfg_ready   = 1'b1;
  assign cfg_wr.wr   = cfg_valid;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  aaie_front u_front (
    .in_word  (in_data),
    .dec_word (dec_word)
  );

  aaie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_word (dec_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_word  (q_word)
  );

  aaie_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .q_not_empty (q_not_empty),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/insn_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the accumulator alu instruction core: tracks the cpu state
// word by word and checks every result word in order; depends on aaie_pkg
package insn_scoreboard_pkg;
  import aaie_pkg::*;

  class insn_scoreboard;
    logic [15:0] start_vals [6];
    logic [7:0]  acc, rb, rc, rd, re, rh, rl;
    logic [15:0] pc;
    logic [3:0]  flags;
    logic        halt;
    out_t        awaited [$];
    int          mismatches;
    int          results_seen;

    function new();
      foreach (start_vals[i]) start_vals[i] = '0;
      halt = 1'b0;
      mismatches = 0;
      results_seen = 0;
      reload();
    endfunction

    function void reload();
      pc    = start_vals[CFG_START_PC];
      acc   = start_vals[CFG_START_ACC][7:0];
      rb    = start_vals[CFG_START_BC][15:8];
      rc    = start_vals[CFG_START_BC][7:0];
      rd    = start_vals[CFG_START_DE][15:8];
      re    = start_vals[CFG_START_DE][7:0];
      rh    = start_vals[CFG_START_HL][15:8];
      rl    = start_vals[CFG_START_HL][7:0];
      flags = start_vals[CFG_START_FLAGS][3:0];
    endfunction

    function void write_start(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx > CFG_START_FLAGS) return;
      case (idx)
        CFG_START_ACC:   start_vals[idx] = {8'h00, data[7:0]};
        CFG_START_FLAGS: start_vals[idx] = {12'h000, data[3:0]};
        default:         start_vals[idx] = data;
      endcase
      reload();
    endfunction

    function void alu_result(logic [8:0] r, bit keep_carry);
      acc = r[7:0];
      flags[FLAG_Z_BIT]  = (r[7:0] == 8'h00);
      flags[FLAG_S_BIT]  = r[7];
      flags[FLAG_P_BIT]  = ~^r[7:0];
      flags[FLAG_CY_BIT] = keep_carry & r[8];
    endfunction

    function void note_insn(in_t w);
      logic [7:0] src;
      logic [7:0] a;
      logic [8:0] cy;
      out_t s;
      if (!halt) begin
        if (w.opcode == OP_NOP) begin
          pc = pc + 16'd1;
        end else if (w.opcode == OP_LXI_B) begin
          rc = w.imm_low;
          rb = w.imm_high;
          pc = pc + 16'd3;
        end else if (w.opcode >= OP_ALU_LO && w.opcode <= OP_ALU_HI) begin
          a  = acc;
          cy = {8'h00, flags[FLAG_CY_BIT]};
          case (src_t'(w.opcode[2:0]))
            SRC_B:   src = rb;
            SRC_C:   src = rc;
            SRC_D:   src = rd;
            SRC_E:   src = re;
            SRC_H:   src = rh;
            SRC_L:   src = rl;
            SRC_M:   src = w.mem_at_hl;
            default: src = a;
          endcase
          case (alu_op_t'(w.opcode[5:3]))
            ALU_ADD: alu_result({1'b0, a} + {1'b0, src}, 1'b1);
            ALU_ADC: alu_result({1'b0, a} + {1'b0, src} + cy, 1'b1);
            ALU_SUB: alu_result({1'b0, a} - {1'b0, src}, 1'b1);
            ALU_SBB: alu_result({1'b0, a} - {1'b0, src} - cy, 1'b1);
            default: alu_result({1'b0, a & src}, 1'b0);
          endcase
          pc = pc + 16'd1;
        end else begin
          halt = 1'b1;
        end
      end
      s.next_pc     = pc;
      s.acc_out     = acc;
      s.bc_out      = {rb, rc};
      s.hl_addr     = {rh, rl};
      s.zero_flag   = flags[FLAG_Z_BIT];
      s.sign_flag   = flags[FLAG_S_BIT];
      s.parity_flag = flags[FLAG_P_BIT];
      s.carry_flag  = flags[FLAG_CY_BIT];
      s.halted      = halt;
      awaited.push_back(s);
    endfunction

    function string show(out_t s);
      return $sformatf("pc=%h a=%h bc=%h hl=%h z=%b s=%b p=%b cy=%b halt=%b",
                       s.next_pc, s.acc_out, s.bc_out, s.hl_addr, s.zero_flag,
                       s.sign_flag, s.parity_flag, s.carry_flag, s.halted);
    endfunction

    function void check_state(out_t got);
      out_t  want;
      string bad;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %0d not expected: %s", results_seen, show(got));
        return;
      end
      want = awaited.pop_front();
      bad = "";
      if (got.next_pc !== want.next_pc)         bad = {bad, " next_pc"};
      if (got.acc_out !== want.acc_out)         bad = {bad, " acc_out"};
      if (got.bc_out !== want.bc_out)           bad = {bad, " bc_out"};
      if (got.hl_addr !== want.hl_addr)         bad = {bad, " hl_addr"};
      if (got.zero_flag !== want.zero_flag)     bad = {bad, " zero_flag"};
      if (got.sign_flag !== want.sign_flag)     bad = {bad, " sign_flag"};
      if (got.parity_flag !== want.parity_flag) bad = {bad, " parity_flag"};
      if (got.carry_flag !== want.carry_flag)   bad = {bad, " carry_flag"};
      if (got.halted !== want.halted)           bad = {bad, " halted"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word %0d wrong in%s", results_seen, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass
endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// top of the testbench for accumulator_alu_instruction_exec_core: drives
// instruction and start-value words, checks results; needs insn_scoreboard_pkg
module tb_top;
  import aaie_pkg::*;
  import insn_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_t                   in_data = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  out_t                  out_data;

  insn_scoreboard sb = new();

  int words_in = 0;
  int words_out = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       stall_run = 0;

  accumulator_alu_instruction_exec_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_BURSTY: begin
        if (stall_run > 0) begin
          stall_run--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_run = $urandom_range(1, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_start(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        sb.note_insn(in_data);
        words_in++;
      end
      if (out_valid && out_ready) begin
        sb.check_state(out_data);
        words_out++;
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] alu_opcode(alu_op_t op, src_t s);
    return OP_ALU_LO | {2'b00, op, s};
  endfunction

  function automatic in_t random_insn();
    in_t w;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 75)
      w.opcode = OP_ALU_LO + 8'($urandom_range(0, 39));
    else if (r < 87)
      w.opcode = OP_NOP;
    else
      w.opcode = OP_LXI_B;
    w.imm_low   = pick_byte();
    w.imm_high  = pick_byte();
    w.mem_at_hl = pick_byte();
    return w;
  endfunction

  task automatic send_insn(in_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic set_start(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_start(logic [15:0] pc, logic [15:0] acc, logic [15:0] bc,
                               logic [15:0] de, logic [15:0] hl, logic [15:0] fl);
    set_start(CFG_START_PC, pc);
    set_start(CFG_START_ACC, acc);
    set_start(CFG_START_BC, bc);
    set_start(CFG_START_DE, de);
    set_start(CFG_START_HL, hl);
    set_start(CFG_START_FLAGS, fl);
    // unused index, must leave everything alone
    set_start(CFG_IDX_W'(CFG_START_FLAGS + 1 + $urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic settle();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_insn(random_insn());
      left -= burst;
      if ($urandom_range(0, 9) < 3)
        gap = 0;
      else if ($urandom_range(0, 9) == 0)
        gap = $urandom_range(7, 20);
      else
        gap = $urandom_range(1, 6);
      pause_sender(gap);
    end
  endtask

  initial begin
    in_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // state straight out of reset
    send_insn({OP_NOP, 8'hFF, 8'hFF, 8'hFF});
    settle();

    // extremes, pc close to the top so it wraps
    program_start(16'hFFFE, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h807F, 16'hFFFF);
    send_insn({OP_LXI_B, 8'hFF, 8'h00, 8'h00});
    for (int k = 0; k < 16; k++) begin
      w.opcode    = alu_opcode(alu_op_t'(k % 5), src_t'(k % 8));
      w.imm_low   = k[0] ? 8'hFF : 8'h00;
      w.imm_high  = k[0] ? 8'h00 : 8'hFF;
      w.mem_at_hl = (k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hFF : 8'h80);
      send_insn(w);
    end
    send_insn({OP_NOP, 8'h00, 8'h00, 8'h00});

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: program_start(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: program_start(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: program_start(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      random_phase(155);
    end

    // undefined opcode halts for good; later words are ignored
    settle();
    w = random_insn();
    do w.opcode = 8'($urandom);
    while (w.opcode == OP_NOP || w.opcode == OP_LXI_B ||
           (w.opcode >= OP_ALU_LO && w.opcode <= OP_ALU_HI));
    send_insn(w);
    repeat (8) begin
      w = random_insn();
      w.opcode = 8'($urandom);
      send_insn(w);
    end
    settle();
    program_start(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    repeat (8) begin
      w = random_insn();
      w.opcode = 8'($urandom);
      send_insn(w);
    end
    settle();

    $display("covered %0d instruction words, %0d result words and %0d register writes",
             words_in, words_out, cfg_writes);
    $display("eight start settings incl. all-zero and all-one, ending halted; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
